// ===== rtl/core/pss_pkg.sv =====
// Package for the photon splitting spectrum unit: fixed-point formats, constants,
// mode and status codes and the side-band records that travel down the pipeline.
// No dependencies.
`default_nettype none

package pss_pkg;

	// Internal fixed-point format: Q28 for ratios, logs and kernels.
	localparam int WB = 28;
	// Fraction bits of the result.
	localparam int OUT_FRAC_BITS = 24;
	localparam int OUT_SH = 64 - OUT_FRAC_BITS;

	localparam int IN_W  = 25;
	localparam int OUT_W = 41;

	// log2 result: integer part (0..27) above WB fraction bits.
	localparam int LOG_KW  = 5;
	localparam int LOG_W   = LOG_KW + WB;
	// Normalised mantissa of the log unit, 1.0 = 2^30.
	localparam int MANT_W  = 31;

	localparam int E_W     = 30;
	localparam int AFAC_W  = 31;

	localparam logic [WB:0]       ONE_Q    = (WB + 1)'(1) << WB;
	localparam logic [E_W-1:0]    E_Q28    = 30'd729683222;
	localparam logic [WB-1:0]     LN2_Q28  = 28'd186065280;
	localparam logic [AFAC_W-1:0] AFAC_Q40 = 31'd1276983506;

	localparam logic [OUT_W-1:0] POS_SAT = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] NEG_SAT = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_FERMION = 2'd0,
		MODE_SCALAR  = 2'd1,
		MODE_VECTOR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_CUT = 2'd1,
		ST_ERR = 2'd2
	} status_t;

	// Flags gathered before the ratio dividers.
	typedef struct packed {
		logic [1:0] mode;
		logic       bad;
		logic       uovf;
		logic       bbig;
		logic       ut;
	} pre_side_t;

	// Early decision carried alongside the log and kernel datapaths.
	typedef struct packed {
		logic [1:0] mode;
		logic       done;
		status_t    st;
	} post_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/photon_splitting_spectrum_unit.sv =====
// Photon splitting spectrum unit: Altarelli-Parisi kernel times the logarithmic
// prefactor alpha/(2 pi) * (ln((1-u)/b^2) - 1), in fixed point.
// Depends on pss_pkg, pss_div and pss_log2.
//
// Usage. Items enter on the request channel (req_valid, req_stall) carrying
// mode, x, beta and z; each item gives exactly one result on the response
// channel (rsp_valid, rsp_stall) carrying dndx (signed Q16.24) and status.
// An item is taken on a rising edge with valid high and stall low.
//
// Throughput is one item per clock while the receiver does not stall. The
// latency is set mainly by the kernel divider, which resolves 57 quotient
// bits one per stage, plus the 28-stage ratio dividers ahead of it; the two
// log units (29 stages each) run in parallel with the kernel divider.
//
// Reset clears every valid bit; data registers are not reset. When the
// receiver stalls with a result waiting, the whole pipeline holds, and
// req_stall is raised in the same cycle, so no item is lost or repeated.
`default_nettype none

module photon_splitting_spectrum_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        mode,
	input  logic [pss_pkg::IN_W-1:0]          x,
	input  logic [pss_pkg::IN_W-1:0]          beta,
	input  logic [pss_pkg::IN_W-1:0]          z,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [pss_pkg::OUT_W-1:0]  dndx,
	output logic [1:0]                        status
);
	import pss_pkg::*;

	localparam int UB_NW   = WB;
	localparam int K_NW    = 2 * WB + 1;
	localparam int LOG_LAT = WB + 1;
	localparam int VLEN    = 2 + UB_NW + 3 + (1 + K_NW + 1 + 3);
	localparam int PDLY    = (K_NW + 2) - (LOG_LAT + 4);
	localparam int SDLY    = K_NW + 1;
	localparam int PM_W    = LOG_W + 1;
	localparam int PRE_W   = PM_W + AFAC_W - 32;
	localparam int KS_W    = K_NW + 1;
	localparam int PR_W    = KS_W + PRE_W;

	// Pipeline control: one enable for every stage, valid bits shifted alongside.
	logic            en;
	logic [VLEN-1:0] vld_s;

	assign rsp_valid = vld_s[VLEN-1];
	assign en        = !(vld_s[VLEN-1] && rsp_stall);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[VLEN-2:0], req_valid};
		end
	end

	// Stage 1: input register.
	logic [1:0]      mode_s1;
	logic [IN_W-1:0] x_s1, beta_s1, z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			x_s1    <= x;
			beta_s1 <= beta;
			z_s1    <= z;
		end
	end

	// Stage 2: the integer part of x/z is 0 or 1 unless u is two or more,
	// in which case the item is cut anyway. The remainder starts the divider.
	logic      bad_1, uovf_1, ut_1, bbig_1;
	logic [IN_W-1:0] ur_1;

	always_comb begin
		bad_1  = !(mode_s1 == MODE_FERMION || mode_s1 == MODE_SCALAR ||
			mode_s1 == MODE_VECTOR) || (z_s1 == '0);
		uovf_1 = {1'b0, x_s1} >= {z_s1, 1'b0};
		ut_1   = x_s1 >= z_s1;
		ur_1   = ut_1 ? x_s1 - z_s1 : x_s1;
		bbig_1 = beta_s1 >= z_s1;
	end

	pre_side_t       sa_s2;
	logic [IN_W-1:0] ur_s2, beta_s2, z_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s2   <= '{mode: mode_s1, bad: bad_1, uovf: uovf_1, bbig: bbig_1, ut: ut_1};
			ur_s2   <= ur_1;
			beta_s2 <= beta_s1;
			z_s2    <= z_s1;
		end
	end

	// Ratio dividers: u = x/z and b = beta/z in Q28.
	logic [UB_NW-1:0] uq, bq;

	pss_div #(.NW(UB_NW), .DW(IN_W)) u_div_u (
		.clk  (clk),
		.en   (en),
		.rem0 (ur_s2),
		.num  ('0),
		.den  (z_s2),
		.quo  (uq)
	);

	pss_div #(.NW(UB_NW), .DW(IN_W)) u_div_b (
		.clk  (clk),
		.en   (en),
		.rem0 (beta_s2),
		.num  ('0),
		.den  (z_s2),
		.quo  (bq)
	);

	pre_side_t sa_dl [UB_NW];

	always_ff @(posedge clk) begin
		if (en) begin
			sa_dl[0] <= sa_s2;
			for (int i = 1; i < UB_NW; i++) begin
				sa_dl[i] <= sa_dl[i-1];
			end
		end
	end

	// Stage 3: b^2.
	logic [2*WB-1:0] bsq;
	logic [WB:0]     u_s3;
	logic [WB-1:0]   b2_s3;
	pre_side_t       sa_s3;

	assign bsq = (2 * WB)'(bq) * (2 * WB)'(bq);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s3  <= {sa_dl[UB_NW-1].ut, uq};
			b2_s3 <= bsq[2*WB-1:WB];
			sa_s3 <= sa_dl[UB_NW-1];
		end
	end

	// Stage 4: threshold 1 - e*b^2, which may go negative.
	logic [E_W+WB-1:0]     ebp;
	logic signed [WB+2:0]  thr_3;
	logic signed [WB+2:0]  thr_s4;
	logic [WB:0]           u_s4;
	logic [WB-1:0]         b2_s4;
	pre_side_t             sa_s4;

	always_comb begin
		ebp   = (E_W + WB)'(E_Q28) * (E_W + WB)'(b2_s3);
		thr_3 = $signed({2'b00, ONE_Q}) - $signed({1'b0, ebp[E_W+WB-1:WB]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			thr_s4 <= thr_3;
			u_s4   <= u_s3;
			b2_s4  <= b2_s3;
			sa_s4  <= sa_s3;
		end
	end

	// Stage 5: early decisions. Items settled here carry a done flag and
	// their status through the rest of the pipeline; the datapath still runs.
	logic       cut_4;
	post_side_t ps_4;
	logic [WB-1:0] w_4;

	always_comb begin
		cut_4 = sa_s4.uovf || ($signed({2'b00, u_s4}) > thr_s4);
		w_4   = WB'(ONE_Q - u_s4);
		ps_4  = '{mode: sa_s4.mode, done: 1'b0, st: ST_OK};
		if (sa_s4.bad) begin
			ps_4.done = 1'b1;
			ps_4.st   = ST_ERR;
		end else if (sa_s4.bbig || cut_4) begin
			ps_4.done = 1'b1;
			ps_4.st   = ST_CUT;
		end else if (b2_s4 == '0 || u_s4 == '0 || u_s4[WB]) begin
			ps_4.done = 1'b1;
			ps_4.st   = ST_ERR;
		end
	end

	logic [WB-1:0] u_s5, w_s5, b2_s5;
	post_side_t    ps_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s5  <= u_s4[WB-1:0];
			w_s5  <= w_4;
			b2_s5 <= b2_s4;
			ps_s5 <= ps_4;
		end
	end

	// Log branch: log2(1-u) - log2(b^2), scaled by ln 2, less one, times alpha/(2 pi).
	logic [LOG_W-1:0] lw, lb;

	pss_log2 u_log_w (
		.clk (clk),
		.en  (en),
		.n   (w_s5),
		.lg  (lw)
	);

	pss_log2 u_log_b (
		.clk (clk),
		.en  (en),
		.n   (b2_s5),
		.lg  (lb)
	);

	logic             lneg_s7;
	logic [LOG_W-1:0] lmag_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_s7 <= lb > lw;
			lmag_s7 <= (lb > lw) ? lb - lw : lw - lb;
		end
	end

	logic [LOG_W+WB-1:0] lnprod;
	logic                lneg_s8;
	logic [LOG_W-1:0]    lnmag_s8;

	assign lnprod = (LOG_W + WB)'(lmag_s7) * (LOG_W + WB)'(LN2_Q28);

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_s8  <= lneg_s7;
			lnmag_s8 <= lnprod[LOG_W+WB-1:WB];
		end
	end

	// Subtracting one: the sign of the prefactor is kept apart from its size.
	logic            pneg_8;
	logic [PM_W-1:0] pmag_8;

	always_comb begin
		if (lneg_s8) begin
			pneg_8 = 1'b1;
			pmag_8 = PM_W'(lnmag_s8) + PM_W'(ONE_Q);
		end else if (PM_W'(lnmag_s8) >= PM_W'(ONE_Q)) begin
			pneg_8 = 1'b0;
			pmag_8 = PM_W'(lnmag_s8) - PM_W'(ONE_Q);
		end else begin
			pneg_8 = 1'b1;
			pmag_8 = PM_W'(ONE_Q) - PM_W'(lnmag_s8);
		end
	end

	logic            pneg_s9;
	logic [PM_W-1:0] pmag_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			pneg_s9 <= pneg_8;
			pmag_s9 <= pmag_8;
		end
	end

	logic [PM_W+AFAC_W-1:0] preprod;
	logic                   pneg_s10;
	logic [PRE_W-1:0]       premag_s10;

	assign preprod = (PM_W + AFAC_W)'(pmag_s9) * (PM_W + AFAC_W)'(AFAC_Q40);

	always_ff @(posedge clk) begin
		if (en) begin
			pneg_s10   <= pneg_s9;
			premag_s10 <= preprod[PM_W+AFAC_W-1:32];
		end
	end

	// Hold the prefactor until the kernel catches up.
	logic [PRE_W:0] pre_dl [PDLY];

	always_ff @(posedge clk) begin
		if (en) begin
			pre_dl[0] <= {pneg_s10, premag_s10};
			for (int i = 1; i < PDLY; i++) begin
				pre_dl[i] <= pre_dl[i-1];
			end
		end
	end

	// Kernel branch, stage 6: (1-u)^2 and u(1-u).
	logic [2*WB-1:0] wsq, uwp;
	logic [WB-1:0]   ww_s6, uw_s6, u_s6, w_s6;
	logic [1:0]      mode_s6;

	always_comb begin
		wsq = (2 * WB)'(w_s5) * (2 * WB)'(w_s5);
		uwp = (2 * WB)'(u_s5) * (2 * WB)'(w_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s6   <= wsq[2*WB-1:WB];
			uw_s6   <= uwp[2*WB-1:WB];
			u_s6    <= u_s5;
			w_s6    <= w_s5;
			mode_s6 <= ps_s5.mode;
		end
	end

	// Numerators for the shared divide by u, and the vector term u/(1-u).
	logic [K_NW-1:0] num_a, num_b;

	always_comb begin
		case (mode_s6)
			MODE_FERMION: begin
				num_a = {ONE_Q + {1'b0, ww_s6}, WB'(0)};
			end
			MODE_SCALAR: begin
				num_a = {w_s6, (WB + 1)'(0)};
			end
			MODE_VECTOR: begin
				num_a = {1'b0, w_s6, WB'(0)};
			end
			default: begin
				num_a = '0;
			end
		endcase
		num_b = {1'b0, u_s6, WB'(0)};
	end

	logic [K_NW-1:0] qa, qb;

	pss_div #(.NW(K_NW), .DW(WB)) u_div_ka (
		.clk  (clk),
		.en   (en),
		.rem0 ('0),
		.num  (num_a),
		.den  (u_s6),
		.quo  (qa)
	);

	pss_div #(.NW(K_NW), .DW(WB)) u_div_kb (
		.clk  (clk),
		.en   (en),
		.rem0 ('0),
		.num  (num_b),
		.den  (w_s6),
		.quo  (qb)
	);

	logic [WB-1:0] uw_dl [K_NW];
	post_side_t    ps_dl [SDLY];

	always_ff @(posedge clk) begin
		if (en) begin
			uw_dl[0] <= uw_s6;
			for (int i = 1; i < K_NW; i++) begin
				uw_dl[i] <= uw_dl[i-1];
			end
			ps_dl[0] <= ps_s5;
			for (int i = 1; i < SDLY; i++) begin
				ps_dl[i] <= ps_dl[i-1];
			end
		end
	end

	// Stage 11: kernel value.
	logic [KS_W-1:0] ksum;
	logic [KS_W-1:0] k_s11;
	post_side_t      ps_s11;

	assign ksum = KS_W'(uw_dl[K_NW-1]) + KS_W'(qa) + KS_W'(qb);

	always_ff @(posedge clk) begin
		if (en) begin
			k_s11  <= (ps_dl[SDLY-1].mode == MODE_VECTOR) ? ksum << 1 : KS_W'(qa);
			ps_s11 <= ps_dl[SDLY-1];
		end
	end

	// Stage 12: kernel times prefactor as two partial products.
	logic [32+PRE_W-1:0]      p0_s12;
	logic [KS_W-32+PRE_W-1:0] p1_s12;
	logic                     pneg_s12;
	post_side_t               ps_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s12   <= (32 + PRE_W)'(k_s11[31:0]) *
				(32 + PRE_W)'(pre_dl[PDLY-1][PRE_W-1:0]);
			p1_s12   <= (KS_W - 32 + PRE_W)'(k_s11[KS_W-1:32]) *
				(KS_W - 32 + PRE_W)'(pre_dl[PDLY-1][PRE_W-1:0]);
			pneg_s12 <= pre_dl[PDLY-1][PRE_W];
			ps_s12   <= ps_s11;
		end
	end

	// Stage 13: sum of the partial products.
	logic [PR_W-1:0] prod_s13;
	logic            pneg_s13;
	post_side_t      ps_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s13 <= PR_W'(p0_s12) + (PR_W'(p1_s12) << 32);
			pneg_s13 <= pneg_s12;
			ps_s13   <= ps_s12;
		end
	end

	// Stage 14: scale to the output format, saturate and apply the sign.
	logic [PR_W-1:0]  magx;
	logic [OUT_W-1:0] res_13;
	status_t          st_13;

	always_comb begin
		magx = prod_s13 >> OUT_SH;
		if (ps_s13.done) begin
			res_13 = '0;
			st_13  = ps_s13.st;
		end else if (pneg_s13) begin
			if (magx > PR_W'(NEG_SAT)) begin
				res_13 = NEG_SAT;
				st_13  = ST_ERR;
			end else begin
				res_13 = OUT_W'(0) - magx[OUT_W-1:0];
				st_13  = ST_OK;
			end
		end else begin
			if (magx > PR_W'(POS_SAT)) begin
				res_13 = POS_SAT;
				st_13  = ST_ERR;
			end else begin
				res_13 = magx[OUT_W-1:0];
				st_13  = ST_OK;
			end
		end
	end

	logic [OUT_W-1:0] dndx_s14;
	status_t          status_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			dndx_s14   <= res_13;
			status_s14 <= st_13;
		end
	end

	assign dndx   = $signed(dndx_s14);
	assign status = status_s14;

endmodule

`default_nettype wire

// ===== rtl/core/pss_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Stand-alone; used by the photon splitting spectrum unit.
`default_nettype none

module pss_div #(
	parameter int NW = 28,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem0,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] den_s [NW];

	logic [DW-1:0] rem_in [NW];
	logic [NW-1:0] nq_in  [NW];
	logic [DW-1:0] den_in [NW];
	logic [DW:0]   tr     [NW];
	logic          ge     [NW];
	logic [DW-1:0] rem_nx [NW];
	logic [NW-1:0] nq_nx  [NW];

	// The remainder stays below the divisor, so the trial value fits DW+1 bits.
	always_comb begin
		rem_in[0] = rem0;
		nq_in[0]  = num;
		den_in[0] = den;
		for (int i = 1; i < NW; i++) begin
			rem_in[i] = rem_s[i-1];
			nq_in[i]  = nq_s[i-1];
			den_in[i] = den_s[i-1];
		end
		for (int i = 0; i < NW; i++) begin
			tr[i]     = {rem_in[i], nq_in[i][NW-1]};
			ge[i]     = tr[i] >= {1'b0, den_in[i]};
			rem_nx[i] = ge[i] ? DW'(tr[i] - {1'b0, den_in[i]}) : tr[i][DW-1:0];
			nq_nx[i]  = {nq_in[i][NW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				rem_s[i] <= rem_nx[i];
				nq_s[i]  <= nq_nx[i];
				den_s[i] <= den_in[i];
			end
		end
	end

	assign quo = nq_s[NW-1];

endmodule

`default_nettype wire

// ===== rtl/core/pss_log2.sv =====
// Pipelined base-2 logarithm in Q28 by repeated squaring, one fraction bit per stage.
// Depends on pss_pkg for the formats.
`default_nettype none

module pss_log2 (
	input  logic                       clk,
	input  logic                       en,
	input  logic [pss_pkg::WB-1:0]     n,
	output logic [pss_pkg::LOG_W-1:0]  lg
);
	import pss_pkg::*;

	localparam int SQ_W = 2 * MANT_W;

	logic [LOG_KW-1:0] k_s [WB+1];
	logic [MANT_W-1:0] m_s [WB+1];
	logic [WB-1:0]     f_s [WB+1];

	logic [LOG_KW-1:0] k0;
	logic [MANT_W-1:0] n_ext;
	logic [MANT_W-1:0] m0;
	logic [SQ_W-1:0]   sq   [WB];
	logic [MANT_W:0]   tt   [WB];
	logic [MANT_W-1:0] m_nx [WB];
	logic [WB-1:0]     f_nx [WB];

	// Leading one and normalisation so that the mantissa lies in [2^30, 2^31).
	always_comb begin
		k0 = '0;
		for (int i = 0; i < WB; i++) begin
			if (n[i]) begin
				k0 = LOG_KW'(i);
			end
		end
		n_ext = MANT_W'(n);
		m0    = n_ext << (LOG_KW'(MANT_W - 1) - k0);
	end

	always_comb begin
		for (int j = 0; j < WB; j++) begin
			sq[j]   = SQ_W'(m_s[j]) * SQ_W'(m_s[j]);
			tt[j]   = sq[j][SQ_W-1:MANT_W-1];
			m_nx[j] = tt[j][MANT_W] ? tt[j][MANT_W:1] : tt[j][MANT_W-1:0];
			f_nx[j] = {f_s[j][WB-2:0], tt[j][MANT_W]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s[0] <= k0;
			m_s[0] <= m0;
			f_s[0] <= '0;
			for (int j = 0; j < WB; j++) begin
				k_s[j+1] <= k_s[j];
				m_s[j+1] <= m_nx[j];
				f_s[j+1] <= f_nx[j];
			end
		end
	end

	assign lg = {k_s[WB], f_s[WB]};

endmodule

`default_nettype wire
